>>> design/thm_pkg.sv
package thm_pkg;

  localparam int unsigned SpW    = 10;
  localparam int unsigned HystW  = 7;
  localparam int unsigned StepW  = 7;
  localparam int unsigned TempW  = 11;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned NMenu  = 15;

  localparam logic [SpW-1:0] SetpointMax  = 10'd999;
  localparam logic [SpW-1:0] UpperReset   = 10'd400;
  localparam logic [SpW-1:0] LowerReset   = 10'd0;
  localparam logic [HystW-1:0] HystReset  = 7'd5;
  localparam logic [StepW-1:0] StepReset  = 7'd1;
  localparam logic [SpW-1:0] FloorReset   = 10'd10;

  // register indexes
  localparam logic [1:0] CfgHyst  = 2'd0;
  localparam logic [1:0] CfgStep  = 2'd1;
  localparam logic [1:0] CfgFloor = 2'd2;

  // key bit positions, active low
  localparam int unsigned KeySelect = 0;
  localparam int unsigned KeyNext   = 1;
  localparam int unsigned KeyPrev   = 2;
  localparam int unsigned KeyBack   = 3;

  typedef enum logic [1:0] {
    CMD_BUTTON  = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_SAMPLE  = 2'd2
  } cmd_e;

  // one-hot menu state; bit position is the menu code
  typedef enum logic [NMenu-1:0] {
    MENU_MAIN     = 15'h0001,
    MENU_1        = 15'h0002,
    MENU_2        = 15'h0004,
    MENU_3        = 15'h0008,
    MENU_4        = 15'h0010,
    MENU_SETMAX   = 15'h0020,
    MENU_SETMIN   = 15'h0040,
    MENU_MAX_INC  = 15'h0080,
    MENU_MAX_DEC  = 15'h0100,
    MENU_MIN_INC  = 15'h0200,
    MENU_MIN_DEC  = 15'h0400,
    MENU_MUTE_TGL = 15'h0800,
    MENU_MUTE_OFF = 15'h1000,
    MENU_COOL_TGL = 15'h2000,
    MENU_COOL_OFF = 15'h4000
  } menu_e;

  typedef struct packed {
    menu_e          menu;
    logic [SpW-1:0] upper;
    logic [SpW-1:0] lower;
    logic           silenced;
    logic           manual;
    logic           cooler;
    logic           buzzer;
  } thm_state_t;

  typedef struct packed {
    logic [HystW-1:0] hyst;
    logic [StepW-1:0] step;
    logic [SpW-1:0]   floor;
  } thm_cfg_t;

endpackage

>>> design/thm_step.sv
module thm_step (
  input  thm_pkg::thm_state_t           state_i,
  input  thm_pkg::thm_cfg_t             cfg_i,
  input  thm_pkg::cmd_e                 cmd_i,
  input  logic [3:0]                    buttons_i,
  input  logic [thm_pkg::TempW-1:0]     temp_i,
  output thm_pkg::thm_state_t           state_o
);
  import thm_pkg::*;

  function automatic menu_e on_select(menu_e m);
    case (m)
      MENU_MAIN: on_select = MENU_1;
      MENU_1:    on_select = MENU_SETMAX;
      MENU_2:    on_select = MENU_SETMIN;
      MENU_3:    on_select = MENU_MUTE_TGL;
      MENU_4:    on_select = MENU_COOL_TGL;
      default:   on_select = MENU_MAIN;
    endcase
  endfunction

  function automatic menu_e on_next(menu_e m);
    case (m)
      MENU_1:      on_next = MENU_2;
      MENU_2:      on_next = MENU_3;
      MENU_3:      on_next = MENU_4;
      MENU_4:      on_next = MENU_1;
      MENU_SETMAX: on_next = MENU_MAX_DEC;
      MENU_SETMIN: on_next = MENU_MIN_DEC;
      default:     on_next = m;
    endcase
  endfunction

  function automatic menu_e on_prev(menu_e m);
    case (m)
      MENU_2:      on_prev = MENU_1;
      MENU_3:      on_prev = MENU_2;
      MENU_4:      on_prev = MENU_3;
      MENU_1:      on_prev = MENU_4;
      MENU_SETMAX: on_prev = MENU_MAX_INC;
      MENU_SETMIN: on_prev = MENU_MIN_INC;
      default:     on_prev = m;
    endcase
  endfunction

  function automatic menu_e on_back(menu_e m);
    case (m)
      MENU_1, MENU_2, MENU_3, MENU_4: on_back = MENU_MAIN;
      MENU_SETMAX: on_back = MENU_1;
      MENU_SETMIN: on_back = MENU_2;
      default:     on_back = m;
    endcase
  endfunction

  function automatic logic [SpW-1:0] sp_inc(logic [SpW-1:0] v, logic [StepW-1:0] s);
    logic [SpW:0] sum;
    sum = {1'b0, v} + {{(SpW+1-StepW){1'b0}}, s};
    sp_inc = (sum > {1'b0, SetpointMax}) ? SetpointMax : sum[SpW-1:0];
  endfunction

  function automatic logic [SpW-1:0] sp_dec(logic [SpW-1:0] v, logic [StepW-1:0] s,
                                            logic [SpW-1:0] fl);
    logic [SpW-1:0] sx;
    sx = {{(SpW-StepW){1'b0}}, s};
    if (v > fl) begin
      sp_dec = (v > sx) ? v - sx : '0;
    end else begin
      sp_dec = v;
    end
  endfunction

  // sample compares in 12-bit signed
  logic signed [TempW:0] t_s, hi_s, lo_s, rel_s;
  menu_e m1, m2, m3, m4;

  assign t_s   = signed'({temp_i[TempW-1], temp_i});
  assign hi_s  = signed'({2'b00, state_i.upper});
  assign lo_s  = signed'({2'b00, state_i.lower});
  assign rel_s = hi_s - signed'({{(TempW+1-HystW){1'b0}}, cfg_i.hyst});

  // keys ripple in order; each sees the state left by the one before
  assign m1 = buttons_i[KeySelect] ? state_i.menu : on_select(state_i.menu);
  assign m2 = buttons_i[KeyNext]   ? m1 : on_next(m1);
  assign m3 = buttons_i[KeyPrev]   ? m2 : on_prev(m2);
  assign m4 = buttons_i[KeyBack]   ? m3 : on_back(m3);

  always_comb begin
    state_o = state_i;
    case (cmd_i)
      CMD_BUTTON: begin
        state_o.menu = m4;
      end
      CMD_REFRESH: begin
        case (state_i.menu)
          MENU_MAX_INC: begin
            state_o.upper = sp_inc(state_i.upper, cfg_i.step);
            state_o.menu  = MENU_SETMAX;
          end
          MENU_MAX_DEC: begin
            state_o.upper = sp_dec(state_i.upper, cfg_i.step, cfg_i.floor);
            state_o.menu  = MENU_SETMAX;
          end
          MENU_MIN_INC: begin
            state_o.lower = sp_inc(state_i.lower, cfg_i.step);
            state_o.menu  = MENU_SETMIN;
          end
          MENU_MIN_DEC: begin
            state_o.lower = sp_dec(state_i.lower, cfg_i.step, cfg_i.floor);
            state_o.menu  = MENU_SETMIN;
          end
          MENU_MUTE_TGL: begin
            state_o.silenced = ~state_i.silenced;
            state_o.buzzer   = 1'b0;
            state_o.menu     = MENU_MAIN;
          end
          MENU_COOL_TGL: begin
            state_o.manual = ~state_i.manual;
            state_o.cooler = ~state_i.manual;
            state_o.menu   = MENU_4;
          end
          default: ;
        endcase
      end
      CMD_SAMPLE: begin
        if (t_s > hi_s) begin
          if (!state_i.silenced) state_o.buzzer = 1'b1;
          if (!state_i.manual)   state_o.cooler = 1'b1;
        end else if (t_s < lo_s) begin
          if (!state_i.silenced) state_o.buzzer = 1'b1;
        end else begin
          state_o.buzzer = 1'b0;
          if (!state_i.manual && (t_s < rel_s)) state_o.cooler = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/thermostat_menu_alarm_controller.sv
// Thermostat menu and alarm controller. Each input beat is a button sample,
// a refresh tick or a temperature sample (tuser selects which); the controller
// updates its menu state, setpoints and pin levels and returns one result beat
// holding the state after the update. One beat is taken every clock cycle while
// s_axis_tready is high: the whole update is one pass through the thm_step logic from
// the state registers back into them, and the result is registered in the output
// register, or in the skid entry if the output register stays full. A second output
// entry (skid) lets the input keep flowing for one beat while the output is stalled;
// s_axis_tready drops only while both entries are full. Configuration writes take
// effect on the next cycle and should be issued while no beat is in flight.
module thermostat_menu_alarm_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [thm_pkg::CfgW-1:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] buttons, [14:4] temperature, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [3:0] menu_state, [4] cooler_out, [5] buzzer_out,
                                      // [6] mute_flag, [7] forced_cooling,
                                      // [17:8] max_setpoint, [27:18] min_setpoint
);
  import thm_pkg::*;

  localparam int unsigned ResW = CodeW + 4 + 2 * SpW;

  thm_cfg_t   cfg_q;
  thm_state_t state_q, state_d;

  logic            s_fire, m_fire;
  logic            out_valid_q, skid_valid_q;
  logic [ResW-1:0] out_data_q, skid_data_q, res_d;
  logic [CodeW-1:0] code_d;

  assign s_fire = s_axis_tvalid & s_axis_tready;
  assign m_fire = out_valid_q & m_axis_tready;
  assign s_axis_tready = ~skid_valid_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst  <= HystReset;
      cfg_q.step  <= StepReset;
      cfg_q.floor <= FloorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHyst:  cfg_q.hyst  <= cfg_data_i[HystW-1:0];
        CfgStep:  cfg_q.step  <= cfg_data_i[StepW-1:0];
        CfgFloor: cfg_q.floor <= cfg_data_i[SpW-1:0];
        default: ;
      endcase
    end
  end

  thm_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd_e'(s_axis_tuser)),
    .buttons_i (s_axis_tdata[3:0]),
    .temp_i    (s_axis_tdata[4 +: TempW]),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.menu     <= MENU_MAIN;
      state_q.upper    <= UpperReset;
      state_q.lower    <= LowerReset;
      state_q.silenced <= 1'b0;
      state_q.manual   <= 1'b0;
      state_q.cooler   <= 1'b0;
      state_q.buzzer   <= 1'b0;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  // one-hot menu to its numeric code
  always_comb begin
    code_d = '0;
    for (int i = 0; i < NMenu; i++) begin
      if (state_d.menu[i]) code_d = CodeW'(i);
    end
  end

  assign res_d = {state_d.lower, state_d.upper, state_d.manual, state_d.silenced,
                  state_d.buzzer, state_d.cooler, code_d};

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s_fire;
      end
    end else if (s_fire) begin
      if (out_valid_q) skid_valid_q <= 1'b1;
      else             out_valid_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_d;
    end else if (s_fire) begin
      if (out_valid_q) skid_data_q <= res_d;
      else             out_data_q  <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(32-ResW){1'b0}}, out_data_q};

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_manual_drives_cooler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.manual |-> state_q.cooler)
    else $error("forced cooling without cooler pin");

  a_mute_clears_buzzer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.silenced |-> !state_q.buzzer)
    else $error("buzzer on while muted");

  a_upper_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q.upper <= SetpointMax))
    else $error("max setpoint beyond saturation value");

endmodule
